// File: sv/simple_moving_average_assert.svh
// ----------------------------------------------------------------------------
// simple_moving_average assertion macros
// shorthand for the clocked checks of the moving average block
// ----------------------------------------------------------------------------
`ifndef SIMPLE_MOVING_AVERAGE_ASSERT_SVH
`define SIMPLE_MOVING_AVERAGE_ASSERT_SVH

// condition must hold at every edge outside reset
`define SMA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sma check failed");

// consequent must hold in the same cycle as the antecedent
`define SMA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sma check failed");

// consequent must hold in the cycle after the antecedent
`define SMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sma check failed");

`endif

// File: sv/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// sizes and helpers for the simple moving average block
// ----------------------------------------------------------------------------
`default_nettype none

package sma_pkg;

  localparam int MAX_WINDOW = 256;

  localparam int PRICE_W = 32;
  localparam int LEN_W   = 9;
  localparam int RING_AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W   = PRICE_W + RING_AW;
  localparam int DIFF_W  = ((RING_AW > LEN_W) ? RING_AW : LEN_W) + 1;

  // divider retires this many quotient bits per cycle
  localparam int DIV_RADIX = 4;
  localparam int DIV_STEPS = (SUM_W + DIV_RADIX - 1) / DIV_RADIX;
  localparam int DIV_W     = DIV_STEPS * DIV_RADIX;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [LEN_W-1:0] LEN_MAX =
    LEN_W'((MAX_WINDOW < (1 << LEN_W)) ? MAX_WINDOW : (1 << LEN_W) - 1);

  // zero means a window of one, anything above the ring depth saturates
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (int'(v) > MAX_WINDOW) begin
      r = LEN_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/simple_moving_average.sv
// ----------------------------------------------------------------------------
// simple_moving_average
// mean of the last window_length closing prices, UQ16.16, truncated
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one price word per handshake, in_tuser set starts a new series
//   out_* : one result word per input word, out_tuser flags a full window;
//           until window_length prices of the series have arrived the word
//           is zero with the flag low
//   cfg_* : window length write, ready while the core is idle and holds off
//           in_tready while pending; clears the running series
// timing:
//   the price ring lives in a one-port-read, one-port-write memory; a word
//   has its ring read at accept, then the sum update and write back and,
//   once the window is full, the radix-16 divider steps, then it lands in
//   the output register; one word is in flight at a time, a new price is
//   taken only after the last result has gone to the output register
// reset: window length 1, empty series, output register empty; the ring
//   itself is not cleared, an entry's value is used only after being written
// stall: the output register holds its word while out_tready is low; the
//   next word is still taken and worked, it waits for the register to free
// ----------------------------------------------------------------------------
`default_nettype none

`include "simple_moving_average_assert.svh"

module simple_moving_average (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [sma_pkg::PRICE_W-1:0] in_tdata,   // [31:0] close_price
  input  wire logic                        in_tuser,   // [0] restart
  // result channel
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [sma_pkg::PRICE_W-1:0]      out_tdata,  // [31:0] average
  output logic                             out_tuser,  // [0] average_valid
  // window length write
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [sma_pkg::LEN_W-1:0]   cfg_data    // [8:0] window_length
);

  import sma_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DIV,
    S_DONE
  } state_t;

  state_t               state_r;
  logic [LEN_W-1:0]     len_r;
  logic [LEN_W-1:0]     cnt_r;
  logic [RING_AW-1:0]   slot_r;
  logic [SUM_W-1:0]     sum_r;
  logic [RING_AW-1:0]   wslot_r;
  logic [PRICE_W-1:0]   price_r;
  logic                 remove_r;
  logic                 valid_r;
  logic [DIV_W-1:0]     q_r;
  logic [LEN_W-1:0]     rem_r;
  logic [STEP_W-1:0]    step_r;
  logic                 out_valid_r;
  logic [PRICE_W-1:0]   out_data_r;
  logic                 out_flag_r;

  logic [PRICE_W-1:0]   ring_mem [MAX_WINDOW];
  logic [PRICE_W-1:0]   ring_rd_r;

  logic                 in_acc;
  logic                 cfg_acc;
  logic [LEN_W-1:0]     cnt_base;
  logic [RING_AW-1:0]   slot_base;
  logic [SUM_W-1:0]     sum_base;
  logic                 remove_w;
  logic [LEN_W-1:0]     cnt_new;
  logic [DIFF_W-1:0]    diff_w;
  logic [DIFF_W-1:0]    old_full;
  logic [RING_AW-1:0]   old_slot;
  logic [RING_AW-1:0]   slot_nxt;
  logic [SUM_W-1:0]     sum_nxt;
  logic [DIV_W-1:0]     q_nxt;
  logic [LEN_W-1:0]     rem_nxt;
  logic                 out_free;
  logic                 out_load;

  // a pending length write goes first
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;
  assign out_free   = !out_valid_r || out_tready;
  assign out_load   = (state_r == S_DONE) && out_free;

  // series bookkeeping for the word being accepted
  always_comb begin
    cnt_base  = in_tuser ? '0 : cnt_r;
    slot_base = in_tuser ? '0 : slot_r;
    sum_base  = in_tuser ? '0 : sum_r;
    remove_w  = (cnt_base >= len_r);
    cnt_new   = remove_w ? cnt_base : cnt_base + LEN_W'(1);
    // slot that leaves the window, wrapped into the ring
    diff_w    = DIFF_W'(slot_base) - DIFF_W'(len_r);
    old_full  = diff_w[DIFF_W-1] ? diff_w + DIFF_W'(MAX_WINDOW) : diff_w;
    old_slot  = old_full[RING_AW-1:0];
    slot_nxt  = (slot_base == RING_AW'(MAX_WINDOW - 1)) ? '0
                                                         : slot_base + RING_AW'(1);
  end

  assign sum_nxt = sum_r - (remove_r ? SUM_W'(ring_rd_r) : '0) + SUM_W'(price_r);

  // restoring divider, DIV_RADIX quotient bits per cycle
  always_comb begin
    logic [LEN_W:0] trial;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    trial   = '0;
    for (int i = 0; i < DIV_RADIX; i++) begin
      trial = {rem_nxt, q_nxt[DIV_W-1]};
      q_nxt = {q_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, len_r}) begin
        trial    = trial - {1'b0, len_r};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = trial[LEN_W-1:0];
    end
  end

  // price ring: read at accept, written back in the update cycle
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      ring_mem[wslot_r] <= price_r;
    end
    if (in_acc) begin
      ring_rd_r <= ring_mem[old_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_W'(1);
      cnt_r       <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cfg_acc) begin
            // a length write restarts the series
            len_r  <= eff_len(cfg_data);
            cnt_r  <= '0;
            slot_r <= '0;
            sum_r  <= '0;
          end else if (in_acc) begin
            price_r  <= in_tdata;
            sum_r    <= sum_base;
            wslot_r  <= slot_base;
            remove_r <= remove_w;
            valid_r  <= (cnt_new >= len_r);
            cnt_r    <= cnt_new;
            slot_r   <= slot_nxt;
            state_r  <= S_UPD;
          end
        end
        S_UPD: begin
          sum_r  <= sum_nxt;
          // warm-up word, nothing to divide
          q_r    <= valid_r ? DIV_W'(sum_nxt) : '0;
          rem_r  <= '0;
          step_r <= '0;
          if (valid_r) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          q_r    <= q_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_data_r <= q_r[PRICE_W-1:0];
            out_flag_r <= valid_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `SMA_ASSERT_ALWAYS(a_cnt_sat, cnt_r <= len_r)
  `SMA_ASSERT_SAME(a_warmup_zero, out_tvalid && !out_tuser, out_tdata == '0)
  `SMA_ASSERT_NEXT(a_full_removes, in_acc && !in_tuser && cnt_r == len_r && !cfg_acc,
                   remove_r && valid_r)
  `SMA_ASSERT_SAME(a_div_bound, state_r == S_DIV, step_r < STEP_W'(DIV_STEPS))

endmodule

`default_nettype wire

// File: verif/simple_moving_average_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// simple_moving_average_tb
// self-checking bench for the moving average block: a local model of the
// price ring and running sum predicts every result word, a checker process
// compares each accepted result against the oldest prediction, with random
// gaps on both streams, long output back-pressure and several window lengths
// ----------------------------------------------------------------------------
module simple_moving_average_tb;

  import sma_pkg::*;

  localparam int RING_DEPTH = sma_pkg::MAX_WINDOW;

  typedef struct packed {
    logic [PRICE_W-1:0] average;
    logic               full;
  } avg_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [PRICE_W-1:0] in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [PRICE_W-1:0] out_tdata;
  logic               out_tuser;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LEN_W-1:0]   cfg_data = '0;

  // local copy of the block state
  logic [PRICE_W-1:0] price_hist [RING_DEPTH];
  logic [SUM_W-1:0]   run_sum;
  logic [LEN_W-1:0]   seen_cnt;
  logic [RING_AW-1:0] next_slot;
  logic [LEN_W-1:0]   window_reg;

  avg_word_t avg_expected[$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold_cycles = 0;

  int items_sent = 0;
  int restarts_sent = 0;
  int results_seen = 0;
  int full_results = 0;
  int windows_written = 0;
  int mismatches = 0;

  simple_moving_average uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] close_price
    .in_tuser   (in_tuser),    // [0] restart
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] average
    .out_tuser  (out_tuser),   // [0] average_valid
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // [8:0] window_length
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("timeout at %0t", $time);
    $display("simple_moving_average verification failed");
    $finish;
  end

  function automatic void clear_series();
    run_sum   = '0;
    seen_cnt  = '0;
    next_slot = '0;
  endfunction

  // moving average of one accepted price word
  function automatic void average_price(input logic [PRICE_W-1:0] price,
                                        input logic restart);
    logic [LEN_W-1:0]   span;
    logic [RING_AW-1:0] drop_slot;
    avg_word_t          w;
    span = window_reg;
    if (span == '0) begin
      span = LEN_W'(1);
    end else if (span > LEN_W'(RING_DEPTH)) begin
      span = LEN_W'(RING_DEPTH);
    end
    if (restart) begin
      clear_series();
    end
    if (seen_cnt >= span) begin
      // oldest price of the window leaves the sum
      drop_slot = next_slot - RING_AW'(span);
      run_sum = run_sum - SUM_W'(price_hist[drop_slot]);
    end else begin
      seen_cnt = seen_cnt + 1'b1;
    end
    price_hist[next_slot] = price;
    run_sum = run_sum + SUM_W'(price);
    next_slot = next_slot + 1'b1;
    if (seen_cnt >= span) begin
      w.average = PRICE_W'(run_sum / SUM_W'(span));
      w.full    = 1'b1;
    end else begin
      w.average = '0;
      w.full    = 1'b0;
    end
    avg_expected = {avg_expected, w};
  endfunction

  function automatic logic [PRICE_W-1:0] rand_price();
    logic [PRICE_W-1:0] p;
    case ($urandom_range(0, 9))
      0: p = '0;
      1: p = '1;
      2: p = PRICE_W'($urandom_range(0, 65535));
      3: p = {16'hFFFF, 16'($urandom_range(0, 65535))};
      default: p = $urandom;
    endcase
    return p;
  endfunction

  task automatic send_price(input logic [PRICE_W-1:0] price, input logic restart);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= price;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    average_price(price, restart);
    items_sent++;
    if (restart) restarts_sent++;
  endtask

  // stop offering and let every outstanding word come back
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_window(input logic [LEN_W-1:0] len);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    window_reg = len;
    clear_series();
    windows_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_series(input int count, input int restart_pct);
    for (int i = 0; i < count; i++) begin
      send_price(rand_price(), ($urandom_range(0, 99) < restart_pct));
    end
  endtask

  // result checker, with its own random ready gaps and long holds
  initial begin : result_check
    int gap;
    avg_word_t w;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 14) : 0;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_seen++;
      if (out_tuser) full_results++;
      if (avg_expected.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h/%b",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        w = avg_expected.pop_front();
        if (out_tdata !== w.average) begin
          $display("%0t: average mismatch, expected %h actual %h",
                   $time, w.average, out_tdata);
          mismatches++;
        end
        if (out_tuser !== w.full) begin
          $display("%0t: average_valid mismatch, expected %b actual %b",
                   $time, w.full, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // reset value of the window is one price
  task automatic test_reset_window();
    send_price('0, 1'b0);
    send_price('1, 1'b0);
    send_price(32'h0001_0000, 1'b0);
    send_price(32'h1234_5678, 1'b1);
  endtask

  task automatic test_window_edges();
    // zero behaves as a window of one
    write_window('0);
    send_price('1, 1'b0);
    send_price(32'h0000_0001, 1'b1);
    // truncation of the mean
    write_window(LEN_W'(2));
    send_price(32'h0000_0001, 1'b0);
    send_price(32'h0000_0002, 1'b0);
    // largest prices, then restart in the middle of a full window
    write_window(LEN_W'(3));
    repeat (4) send_price('1, 1'b0);
    send_price(32'h0000_0005, 1'b1);
    send_price(32'h0000_0006, 1'b0);
    send_price(32'h0000_0007, 1'b0);
    send_price(32'h0000_0008, 1'b0);
  endtask

  task automatic test_saturated_window();
    // above the ring depth, saturates to a full ring
    write_window('1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_series(140, 0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_series(130, 1);
  endtask

  task automatic test_full_window();
    write_window(LEN_W'(RING_DEPTH));
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    run_series(270, 0);
  endtask

  task automatic test_short_windows();
    write_window(LEN_W'(7));
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    run_series(120, 3);
    write_window(LEN_W'(1));
    tx_idle = 1'b1;
    run_series(60, 5);
    repeat (2) begin
      write_window(LEN_W'($urandom_range(2, 40)));
      run_series(80, 2);
    end
  endtask

  // output stalls for a long stretch while the input keeps offering words
  task automatic test_backpressure();
    write_window(LEN_W'(4));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 250;
    run_series(24, 0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    window_reg = LEN_W'(1);
    clear_series();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_window();
    test_window_edges();
    test_backpressure();
    test_saturated_window();
    test_full_window();
    test_short_windows();

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d price words (%0d restarts) over %0d window settings",
             items_sent, restarts_sent, windows_written);
    $display("checked %0d result words, %0d with a full window",
             results_seen, full_results);
    if (mismatches == 0) begin
      $display("simple_moving_average verification clean");
    end else begin
      $display("simple_moving_average verification failed");
    end
    $finish;
  end

endmodule
